// ===== rtl/core/stc_pkg.sv =====
// Shared types, constants and helpers for the script token compiler.
package stc_pkg;

    localparam int NAME_CHARS_DEF  = 8;
    localparam int COUNT_BITS_DEF  = 16;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam int          OP_COUNT    = 45;
    localparam int          OP_NAME_MAX = 6;
    localparam logic [7:0]  OP_SET      = 8'd128;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_UNDER = 8'h5f;
    localparam logic [7:0] CH_DASH  = 8'h2d;

    localparam logic [30:0] NUM_MAX = 31'h7fffffff;

    // Result kinds on the output channel
    typedef enum logic [1:0] {
        KIND_BYTE = 2'd0,
        KIND_DONE = 2'd1,
        KIND_ERR  = 2'd2
    } kind_t;

    // One queued command: a word, a finish, or both, or an error alone
    typedef struct packed {
        logic        has_word;
        logic        is_num;
        logic [30:0] val;
        logic        fin;
        logic        err;
        logic [15:0] tally;
    } stc_cmd_t;

    // Opcode names, right-justified: first character in the highest used byte
    localparam logic [47:0] OP_NAMES [OP_COUNT] = '{
        48'("SET"), 48'("GET"), 48'("INCR"), 48'("DECR"),
        48'("READ"), 48'("WRITE"), 48'("INSERT"), 48'("REMOVE"),
        48'("POKE"), 48'("PEEK"),
        48'("DEF"), 48'("RM"), 48'("RUN"),
        48'("IF"), 48'("ELIF"), 48'("ELSE"), 48'("MATCH"), 48'("WHEN"),
        48'("WHILE"), 48'("DO"), 48'("FOR"), 48'("WAIT"),
        48'("NOT"), 48'("AND"), 48'("OR"), 48'("XOR"),
        48'("BNOT"), 48'("BAND"), 48'("BOR"), 48'("BXOR"),
        48'("LSHIFT"), 48'("RSHIFT"),
        48'("EQ"), 48'("NEQ"), 48'("GTE"), 48'("LTE"), 48'("GT"), 48'("LT"),
        48'("NEG"), 48'("ADD"), 48'("SUB"), 48'("MUL"), 48'("DIV"),
        48'("MOD"), 48'("ABS")
    };

    localparam logic [2:0] OP_LENS [OP_COUNT] = '{
        3'd3, 3'd3, 3'd4, 3'd4,
        3'd4, 3'd5, 3'd6, 3'd6,
        3'd4, 3'd4,
        3'd3, 3'd2, 3'd3,
        3'd2, 3'd4, 3'd4, 3'd5, 3'd4,
        3'd5, 3'd2, 3'd3, 3'd4,
        3'd3, 3'd3, 3'd2, 3'd3,
        3'd4, 3'd4, 3'd3, 3'd4,
        3'd6, 3'd6,
        3'd2, 3'd3, 3'd3, 3'd3, 3'd2, 3'd2,
        3'd3, 3'd3, 3'd3, 3'd3, 3'd3,
        3'd3, 3'd3
    };

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_lower(input logic [7:0] c);
        return (c >= 8'h61) && (c <= 8'h7a);
    endfunction

    function automatic logic is_upper(input logic [7:0] c);
        return (c >= 8'h41) && (c <= 8'h5a);
    endfunction

    function automatic logic is_sep(input logic [7:0] c);
        return (c == CH_NUL) || (c == CH_SPACE) || (c == CH_LF);
    endfunction

    // Match first six characters (char j at [8*j +: 8]) against the name table.
    // Returns the opcode, or zero when nothing matches.
    function automatic logic [7:0] op_lookup(input logic [47:0] chars,
                                             input logic        len_ok,
                                             input logic [2:0]  len);
        logic [7:0] op;
        logic       hit;
        op = '0;
        for (int i = 0; i < OP_COUNT; i++) begin
            hit = len_ok && (len == OP_LENS[i]);
            for (int j = 0; j < OP_NAME_MAX; j++) begin
                if (j < int'(OP_LENS[i])) begin
                    if (chars[8*j +: 8] !=
                        OP_NAMES[i][8*(int'(OP_LENS[i]) - 1 - j) +: 8]) begin
                        hit = 1'b0;
                    end
                end
            end
            if (hit) begin
                op = OP_SET + 8'(i);
            end
        end
        return op;
    endfunction

endpackage

// ===== rtl/core/stc_front.sv =====
// Front end: scans text bytes, tracks the current word and queues commands.
module stc_front #(
    parameter int NAME_CHARS = 8,
    parameter int COUNT_BITS = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             in_stall,
    input  logic [7:0]       in_char,
    output logic             push,
    output stc_pkg::stc_cmd_t push_cmd
);
    import stc_pkg::*;

    localparam int LW = $clog2(NAME_CHARS + 2);
    localparam int IW = $clog2(NAME_CHARS);
    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

    typedef enum logic [2:0] {
        M_IDLE,
        M_NUM,
        M_VAR,
        M_OPW,
        M_HALT
    } mode_t;

    mode_t                 mode_reg,  mode_next;
    logic [30:0]           acc_reg,   acc_next;
    logic [LW-1:0]         nlen_reg,  nlen_next;
    logic [COUNT_BITS-1:0] wpos_reg,  wpos_next;
    logic [4:0]            letter_reg, letter_next;
    logic [COUNT_BITS-1:0] tpos_reg,  tpos_next;
    logic [7:0]            name_buf_reg [NAME_CHARS];
    logic                  buf_we;

    logic                  accept;
    logic [34:0]           acc_x10;
    logic [47:0]           first_chars;
    logic [7:0]            op_code;

    assign accept = in_valid && !in_stall;

    // Times ten plus the new digit, checked for overflow below
    assign acc_x10 = {1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0}
                   + {31'd0, in_char[3:0]};

    // Opcode match on the buffered word
    always_comb
    begin
        for (int j = 0; j < OP_NAME_MAX; j++) begin
            first_chars[8*j +: 8] = name_buf_reg[j];
        end
    end

    assign op_code = op_lookup(first_chars, nlen_reg <= LW'(OP_NAME_MAX), nlen_reg[2:0]);

    // Word state update and command generation
    always_comb
    begin
        logic [COUNT_BITS-1:0] pos;
        logic [COUNT_BITS-1:0] fail_pos;
        logic                  fail;
        logic                  word_end;
        mode_next   = mode_reg;
        acc_next    = acc_reg;
        nlen_next   = nlen_reg;
        wpos_next   = wpos_reg;
        letter_next = letter_reg;
        tpos_next   = tpos_reg;
        buf_we      = 1'b0;
        push        = 1'b0;
        push_cmd    = '0;
        fail        = 1'b0;
        word_end    = 1'b0;
        pos         = (tpos_reg == CNT_MAX) ? tpos_reg : tpos_reg + 1'b1;
        fail_pos    = pos;
        if (accept && mode_reg != M_HALT) begin
            tpos_next = pos;
            unique case (mode_reg)
                M_NUM:
                begin
                    if (is_digit(in_char)) begin
                        if (acc_x10[34:31] != 4'd0) begin
                            fail = 1'b1;
                        end else begin
                            acc_next = acc_x10[30:0];
                        end
                    end else if (is_sep(in_char)) begin
                        word_end          = 1'b1;
                        push_cmd.has_word = 1'b1;
                        push_cmd.is_num   = 1'b1;
                        push_cmd.val      = acc_reg;
                    end else begin
                        fail = 1'b1;
                    end
                end
                M_VAR:
                begin
                    if (is_sep(in_char)) begin
                        word_end          = 1'b1;
                        push_cmd.has_word = 1'b1;
                        push_cmd.val      = {26'd0, letter_reg};
                    end else begin
                        fail = 1'b1;
                    end
                end
                M_OPW:
                begin
                    if (is_upper(in_char) || is_lower(in_char) || is_digit(in_char)
                        || in_char == CH_UNDER || in_char == CH_DASH) begin
                        buf_we = (nlen_reg < LW'(NAME_CHARS));
                        if (nlen_reg < LW'(NAME_CHARS + 1)) begin
                            nlen_next = nlen_reg + 1'b1;
                        end
                    end else if (is_sep(in_char)) begin
                        if (op_code == 8'd0) begin
                            fail     = 1'b1;
                            fail_pos = wpos_reg;
                        end else begin
                            word_end          = 1'b1;
                            push_cmd.has_word = 1'b1;
                            push_cmd.val      = {23'd0, op_code};
                        end
                    end else begin
                        fail = 1'b1;
                    end
                end
                default:
                begin
                    // Between words
                    if (is_digit(in_char)) begin
                        acc_next  = {27'd0, in_char[3:0]};
                        wpos_next = pos;
                        mode_next = M_NUM;
                    end else if (is_lower(in_char)) begin
                        letter_next = 5'(in_char - 8'h61);
                        wpos_next   = pos;
                        mode_next   = M_VAR;
                    end else if (is_upper(in_char)) begin
                        buf_we    = 1'b1;
                        nlen_next = LW'(1);
                        wpos_next = pos;
                        mode_next = M_OPW;
                    end else if (is_sep(in_char)) begin
                        word_end = 1'b1;
                    end else begin
                        fail = 1'b1;
                    end
                end
            endcase

            if (fail) begin
                push_cmd       = '0;
                push_cmd.err   = 1'b1;
                push_cmd.tally = (fail_pos > COUNT_BITS'(16'hffff)) ? 16'hffff
                                                                   : 16'(fail_pos);
                push           = 1'b1;
                mode_next      = M_HALT;
            end else if (word_end) begin
                if (mode_reg != M_IDLE) begin
                    mode_next = M_IDLE;
                end
                if (in_char == CH_NUL) begin
                    push_cmd.fin = 1'b1;
                    mode_next    = M_HALT;
                end
                push = push_cmd.has_word || push_cmd.fin;
            end
        end
    end

    // Control and word state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg   <= M_IDLE;
            acc_reg    <= '0;
            nlen_reg   <= '0;
            wpos_reg   <= '0;
            letter_reg <= '0;
            tpos_reg   <= '0;
        end else begin
            mode_reg   <= mode_next;
            acc_reg    <= acc_next;
            nlen_reg   <= nlen_next;
            wpos_reg   <= wpos_next;
            letter_reg <= letter_next;
            tpos_reg   <= tpos_next;
        end
    end

    // Name characters, unreset; first char at index zero, rest at the length
    always_ff @(posedge clk)
    begin
        if (buf_we) begin
            if (mode_reg == M_OPW) begin
                name_buf_reg[nlen_reg[IW-1:0]] <= in_char;
            end else begin
                name_buf_reg[0] <= in_char;
            end
        end
    end

endmodule

// ===== rtl/core/stc_queue.sv =====
// Small command queue between the front end and the emitter.
module stc_queue #(
    parameter int DEPTH = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  stc_pkg::stc_cmd_t push_cmd,
    input  logic              pop,
    output stc_pkg::stc_cmd_t head,
    output logic              not_empty,
    output logic              full
);
    import stc_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    stc_cmd_t        mem [DEPTH];
    logic [PW-1:0]   wp_reg;
    logic [PW-1:0]   rp_reg;
    logic [CW-1:0]   cnt_reg;
    logic            do_push;
    logic            do_pop;

    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign not_empty = (cnt_reg != '0);
    assign full      = (cnt_reg == CW'(DEPTH));
    assign head      = mem[rp_reg];

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (do_push) begin
            mem[wp_reg] <= push_cmd;
        end
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (do_push) begin
                wp_reg <= (wp_reg == PW'(DEPTH - 1)) ? '0 : wp_reg + 1'b1;
            end
            if (do_pop) begin
                rp_reg <= (rp_reg == PW'(DEPTH - 1)) ? '0 : rp_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/core/stc_emit.sv =====
// Back end: expands commands into results, one per unstalled cycle.
module stc_emit #(
    parameter int COUNT_BITS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  stc_pkg::stc_cmd_t head,
    input  logic              not_empty,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [1:0]        kind,
    output logic [7:0]        code_byte,
    output logic [15:0]       tally,
    output logic              last
);
    import stc_pkg::*;

    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

    logic                  act_reg;
    logic                  word_reg;
    logic                  num_reg;
    logic                  first_reg;
    logic [30:0]           val_reg;
    logic                  fin_reg;
    logic                  err_reg;
    logic [15:0]           etally_reg;
    logic [COUNT_BITS-1:0] clen_reg;

    logic                  out_valid_reg;
    kind_t                 kind_reg;
    logic [7:0]            byte_reg;
    logic [15:0]           tally_reg;
    logic                  last_reg;

    logic                  adv;
    logic                  done;
    logic                  word_done;
    logic                  is_byte;
    kind_t                 r_kind;
    logic [7:0]            r_byte;
    logic [15:0]           r_tally;
    logic [30:0]           val_after;

    assign adv = act_reg && (!out_valid_reg || !out_stall);
    assign pop = not_empty && (!act_reg || (adv && done));

    // Next result of the active command
    always_comb
    begin
        r_kind    = KIND_BYTE;
        r_byte    = '0;
        r_tally   = '0;
        word_done = 1'b0;
        is_byte   = 1'b0;
        val_after = val_reg;
        if (err_reg) begin
            r_kind  = KIND_ERR;
            r_tally = etally_reg;
        end else if (word_reg) begin
            is_byte = 1'b1;
            if (!num_reg) begin
                r_byte    = val_reg[7:0];
                word_done = 1'b1;
            end else if (first_reg) begin
                if (val_reg < 31'h40) begin
                    r_byte    = {2'b00, val_reg[5:0]};
                    word_done = 1'b1;
                end else begin
                    r_byte    = {2'b01, val_reg[5:0]};
                    val_after = val_reg >> 6;
                end
            end else if (val_reg >= 31'h80) begin
                r_byte    = {1'b1, val_reg[6:0]};
                val_after = val_reg >> 7;
            end else begin
                r_byte    = {1'b0, val_reg[6:0]};
                word_done = 1'b1;
            end
        end else begin
            r_kind  = KIND_DONE;
            r_tally = (clen_reg > COUNT_BITS'(16'hffff)) ? 16'hffff : 16'(clen_reg);
        end
        done = err_reg || (word_reg ? (word_done && !fin_reg) : 1'b1);
    end

    // Command sequencing and code length
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            act_reg   <= 1'b0;
            word_reg  <= 1'b0;
            num_reg   <= 1'b0;
            first_reg <= 1'b0;
            fin_reg   <= 1'b0;
            err_reg   <= 1'b0;
            clen_reg  <= '0;
        end else begin
            if (adv && is_byte && clen_reg != CNT_MAX) begin
                clen_reg <= clen_reg + 1'b1;
            end
            if (pop) begin
                act_reg   <= 1'b1;
                word_reg  <= head.has_word;
                num_reg   <= head.is_num;
                first_reg <= 1'b1;
                fin_reg   <= head.fin;
                err_reg   <= head.err;
            end else if (adv && done) begin
                act_reg <= 1'b0;
            end else if (adv) begin
                first_reg <= 1'b0;
                if (word_done) begin
                    word_reg <= 1'b0;
                end
            end
        end
    end

    // Command payload
    always_ff @(posedge clk)
    begin
        if (pop) begin
            val_reg    <= head.val;
            etally_reg <= head.tally;
        end else if (adv) begin
            val_reg <= val_after;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            out_valid_reg <= 1'b1;
        end else if (!out_stall) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv) begin
            kind_reg  <= r_kind;
            byte_reg  <= r_byte;
            tally_reg <= r_tally;
            last_reg  <= done;
        end
    end

    assign out_valid = out_valid_reg;
    assign kind      = kind_reg;
    assign code_byte = byte_reg;
    assign tally     = tally_reg;
    assign last      = last_reg;

endmodule

// ===== rtl/core/script_token_compiler.sv =====
// Script token compiler: text bytes in, bytecode result items out.
// Throughput: one text byte and one result item per cycle, each unless stalled.
// A byte that ends a word is queued, then loaded into the emitter's command
// registers and the output register, and waits longer behind queued commands.
// Input stall rises only when the command queue (QUEUE_DEPTH entries) is full.
// Reset clears all control state at once; no clearing pass is needed.
module script_token_compiler #(
    parameter int NAME_CHARS  = stc_pkg::NAME_CHARS_DEF,
    parameter int COUNT_BITS  = stc_pkg::COUNT_BITS_DEF,
    parameter int QUEUE_DEPTH = stc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  in_char,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  kind,
    output logic [7:0]  code_byte,
    output logic [15:0] tally,
    output logic        last
);
    import stc_pkg::*;

    logic     push;
    stc_cmd_t push_cmd;
    logic     pop;
    stc_cmd_t head;
    logic     not_empty;
    logic     full;

    assign in_stall = full;

    stc_front #(
        .NAME_CHARS (NAME_CHARS),
        .COUNT_BITS (COUNT_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_char  (in_char),
        .push     (push),
        .push_cmd (push_cmd)
    );

    stc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (push_cmd),
        .pop       (pop),
        .head      (head),
        .not_empty (not_empty),
        .full      (full)
    );

    stc_emit #(
        .COUNT_BITS (COUNT_BITS)
    ) u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .not_empty (not_empty),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .kind      (kind),
        .code_byte (code_byte),
        .tally     (tally),
        .last      (last)
    );

endmodule

// ===== rtl/core/stc_checker.sv =====
// Port-level checks for the script token compiler, bound to the top level.
module stc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [1:0]  kind,
    input logic [7:0]  code_byte,
    input logic [15:0] tally,
    input logic        last
);
    import stc_pkg::*;

    // A held result keeps its payload
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(kind) && $stable(code_byte)
                                   && $stable(tally) && $stable(last))
        else $error("stalled result changed");

    // Finish and error always close the input byte's results
    a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == KIND_DONE || kind == KIND_ERR) |-> last)
        else $error("finish or error without last");

    // Only bytecode items carry a byte, and they carry no tally
    a_byte_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_BYTE |-> tally == 16'd0)
        else $error("bytecode item with tally");

    a_nonbyte_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == KIND_DONE || kind == KIND_ERR) |-> code_byte == 8'd0)
        else $error("finish or error with byte");

    // Nothing follows a finish or an error once it is taken
    a_halt: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && (kind == KIND_DONE || kind == KIND_ERR)
        |=> !out_valid)
        else $error("result after program end");

endmodule

bind script_token_compiler stc_checker u_stc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .kind      (kind),
    .code_byte (code_byte),
    .tally     (tally),
    .last      (last)
);
